>>> rtl/sdpg_pkg.sv
// Package: shared types, register codes and constants of the step/dir pulse generator.
`default_nettype none
package sdpg_pkg;

	// Timer decrement per tick, in microseconds
	localparam int unsigned TICK_US = 10;

	localparam int unsigned CFG_INDEX_W = 3;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RUN_FOREVER    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STEPS_TOTAL    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_PERIOD_US = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CAL_MODE       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_LENGTH    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_BOUND      = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_BOUND      = 3'd7;

	// Run status codes
	localparam logic [2:0] ST_IDLE        = 3'd0;
	localparam logic [2:0] ST_RUNNING     = 3'd1;
	localparam logic [2:0] ST_FINISHED_OK = 3'd2;
	localparam logic [2:0] ST_HARD_MIN    = 3'd3;
	localparam logic [2:0] ST_HARD_MAX    = 3'd4;
	localparam logic [2:0] ST_SOFT_MIN    = 3'd5;
	localparam logic [2:0] ST_SOFT_MAX    = 3'd6;

	// Calibration modes
	localparam logic [1:0] CAL_NONE     = 2'd0;
	localparam logic [1:0] CAL_HOLD_MIN = 2'd1;
	localparam logic [1:0] CAL_DRAG_MAX = 2'd2;

	typedef struct packed {
		logic               req_type;
		logic signed [31:0] start_position;
		logic               limit_min;
		logic               limit_max;
	} item_t;

	typedef struct packed {
		logic               step_level;
		logic               step_taken;
		logic [2:0]         run_status;
		logic signed [31:0] position;
		logic signed [31:0] max_bound_now;
		logic               motor_enable;
		logic               cycle_done;
	} result_t;

	typedef struct packed {
		logic               direction;
		logic               run_forever;
		logic [23:0]        steps_total;
		logic [23:0]        step_period_us;
		logic [1:0]         cal_mode;
		logic [19:0]        step_length;
		logic signed [31:0] min_bound;
		logic signed [31:0] max_bound;
	} cfg_t;

endpackage
`default_nettype wire

>>> rtl/sdpg_cfg.sv
// Configuration register file of the step/dir pulse generator.
`default_nettype none
module sdpg_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [sdpg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [31:0]                     cfg_data,
	output sdpg_pkg::cfg_t                       cfg
);

	sdpg_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid && cfg_ready;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction      <= 1'b1;
			cfg_q.run_forever    <= 1'b0;
			cfg_q.steps_total    <= '0;
			cfg_q.step_period_us <= '0;
			cfg_q.cal_mode       <= sdpg_pkg::CAL_NONE;
			cfg_q.step_length    <= 20'd1;
			cfg_q.min_bound      <= '0;
			cfg_q.max_bound      <= '0;
		end else if (wr_en) begin
			unique case (cfg_index)
				sdpg_pkg::REG_DIRECTION:      cfg_q.direction      <= cfg_data[0];
				sdpg_pkg::REG_RUN_FOREVER:    cfg_q.run_forever    <= cfg_data[0];
				sdpg_pkg::REG_STEPS_TOTAL:    cfg_q.steps_total    <= cfg_data[23:0];
				sdpg_pkg::REG_STEP_PERIOD_US: cfg_q.step_period_us <= cfg_data[23:0];
				sdpg_pkg::REG_CAL_MODE:       cfg_q.cal_mode       <= cfg_data[1:0];
				sdpg_pkg::REG_STEP_LENGTH:    cfg_q.step_length    <= cfg_data[19:0];
				sdpg_pkg::REG_MIN_BOUND:      cfg_q.min_bound      <= cfg_data;
				sdpg_pkg::REG_MAX_BOUND:      cfg_q.max_bound      <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/sdpg_core.sv
// Step engine: motor state registers and the per-request step/stop decision.
`default_nettype none
module sdpg_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire sdpg_pkg::item_t item,
	input  wire sdpg_pkg::cfg_t  cfg,
	output sdpg_pkg::result_t    result
);

	localparam logic signed [31:0] TICK     = 32'(sdpg_pkg::TICK_US);
	localparam logic signed [31:0] TICK_TWO = 32'(2 * sdpg_pkg::TICK_US);

	logic [31:0] position_q;
	logic [31:0] max_bound_q;
	logic [31:0] timer_q;
	logic [23:0] steps_left_q;
	logic [2:0]  status_q;
	logic        line_q;
	logic        running_q;

	logic [31:0] position_d;
	logic [31:0] max_bound_d;
	logic [31:0] timer_d;
	logic [23:0] steps_left_d;
	logic [2:0]  status_d;
	logic        line_d;
	logic        running_d;
	logic        taken;
	logic        done;

	logic [31:0]        timer_dec;
	logic signed [31:0] t;
	logic signed [33:0] pos_ext;
	logic signed [33:0] dist_ext;
	logic signed [33:0] lo_ext;
	logic signed [33:0] hi_ext;
	logic               over_hi;
	logic               under_lo;
	logic               fwd;
	logic               hard_hit;
	logic               soft_hit;
	logic               cal_hit;
	logic               can_step;
	logic [23:0]        steps_dec;
	logic [31:0]        step_pos;
	logic [31:0]        reload;

	assign fwd       = cfg.direction;
	assign timer_dec = timer_q - 32'(sdpg_pkg::TICK_US);
	assign t         = signed'(timer_dec);
	assign reload    = {8'd0, cfg.step_period_us};
	assign steps_dec = steps_left_q - 24'd1;

	// Exact bound compares in 34 bits
	assign pos_ext  = {{2{position_q[31]}}, position_q};
	assign dist_ext = {14'd0, cfg.step_length};
	assign lo_ext   = {{2{cfg.min_bound[31]}}, cfg.min_bound};
	assign hi_ext   = {{2{max_bound_q[31]}}, max_bound_q};
	assign over_hi  = (pos_ext + dist_ext) > hi_ext;
	assign under_lo = (pos_ext - dist_ext) < lo_ext;

	assign hard_hit = item.limit_min || item.limit_max;
	assign soft_hit = (cfg.cal_mode == sdpg_pkg::CAL_NONE) && (fwd ? over_hi : under_lo);
	assign cal_hit  = (cfg.cal_mode == sdpg_pkg::CAL_DRAG_MAX) && !fwd && under_lo;
	assign can_step = cfg.run_forever || (steps_left_q != 24'd0);

	always_comb begin
		unique case (cfg.cal_mode)
			sdpg_pkg::CAL_NONE, sdpg_pkg::CAL_DRAG_MAX: begin
				step_pos = fwd ? position_q + {12'd0, cfg.step_length}
				               : position_q - {12'd0, cfg.step_length};
			end
			sdpg_pkg::CAL_HOLD_MIN: step_pos = cfg.min_bound;
			default:                step_pos = position_q;
		endcase
	end

	always_comb begin
		position_d   = position_q;
		max_bound_d  = max_bound_q;
		timer_d      = timer_q;
		steps_left_d = steps_left_q;
		status_d     = status_q;
		line_d       = line_q;
		running_d    = running_q;
		taken        = 1'b0;
		done         = 1'b0;
		if (item.req_type) begin
			position_d   = item.start_position;
			timer_d      = reload;
			steps_left_d = cfg.run_forever ? 24'd0 : cfg.steps_total;
			max_bound_d  = cfg.max_bound;
			status_d     = sdpg_pkg::ST_RUNNING;
			running_d    = 1'b1;
		end else if (running_q) begin
			timer_d = timer_dec;
			priority if (hard_hit) begin
				status_d = fwd ? sdpg_pkg::ST_HARD_MAX : sdpg_pkg::ST_HARD_MIN;
			end else if (soft_hit) begin
				status_d = fwd ? sdpg_pkg::ST_SOFT_MAX : sdpg_pkg::ST_SOFT_MIN;
			end else if (cal_hit) begin
				status_d = sdpg_pkg::ST_SOFT_MIN;
			end else if (can_step) begin
				if (t < TICK_TWO && t >= TICK) begin
					line_d = 1'b1;
				end else if (t < TICK) begin
					line_d  = 1'b0;
					taken   = 1'b1;
					timer_d = reload;
					position_d = step_pos;
					if (cfg.cal_mode == sdpg_pkg::CAL_DRAG_MAX) begin
						max_bound_d = step_pos;
					end
					if (!cfg.run_forever) begin
						steps_left_d = steps_dec;
						if (steps_dec == 24'd0) begin
							status_d = sdpg_pkg::ST_FINISHED_OK;
						end
					end
				end
			end
			// End the cycle on a stop or when no steps remain
			if (!(!hard_hit && !soft_hit && !cal_hit && can_step)) begin
				running_d = 1'b0;
				done      = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q   <= '0;
			max_bound_q  <= '0;
			timer_q      <= '0;
			steps_left_q <= '0;
			status_q     <= sdpg_pkg::ST_IDLE;
			line_q       <= 1'b0;
			running_q    <= 1'b0;
		end else if (accept) begin
			position_q   <= position_d;
			max_bound_q  <= max_bound_d;
			timer_q      <= timer_d;
			steps_left_q <= steps_left_d;
			status_q     <= status_d;
			line_q       <= line_d;
			running_q    <= running_d;
		end
	end

	always_comb begin
		result.step_level    = line_d;
		result.step_taken    = taken;
		result.run_status    = status_d;
		result.position      = position_d;
		result.max_bound_now = max_bound_d;
		result.motor_enable  = running_d;
		result.cycle_done    = done;
	end

endmodule
`default_nettype wire

>>> rtl/sdpg_out_reg.sv
// Result register: holds one finished result until the downstream side takes it.
`default_nettype none
module sdpg_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire sdpg_pkg::result_t result_d,
	input  wire logic              result_stall,
	output logic                   result_valid,
	output sdpg_pkg::result_t      result,
	output logic                   full_stall
);

	logic              valid_q;
	sdpg_pkg::result_t data_q;

	// Accept a new request when no result is held or the held result is being taken
	assign full_stall   = valid_q && result_stall;
	assign result_valid = valid_q;
	assign result       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/step_dir_pulse_generator.sv
// Top level: one step/dir motor channel with result register and config port.
// Result path: the result of an accepted request is registered in sdpg_out_reg and shown at result_valid.
// Throughput: one request per cycle; item_stall follows result_stall while a result waits.
// The step decision is one pass of compare/add logic from the motor state registers.
// Reset: asynchronous, active low; state idle, config at its defaults, no result held.
`default_nettype none
module step_dir_pulse_generator (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire sdpg_pkg::item_t                  item,
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output sdpg_pkg::result_t                     result,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [sdpg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [31:0]                      cfg_data
);

	sdpg_pkg::cfg_t    cfg;
	sdpg_pkg::result_t result_d;
	logic              accept;

	assign accept = item_valid && !item_stall;

	sdpg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sdpg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cfg    (cfg),
		.result (result_d)
	);

	sdpg_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.result_d     (result_d),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.full_stall   (item_stall)
	);

endmodule
`default_nettype wire

>>> rtl/sdpg_checker.sv
// Port-level checker for the step/dir pulse generator, bound to the top level.
`default_nettype none
module sdpg_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             item_valid,
	input wire logic                             item_stall,
	input wire sdpg_pkg::item_t                  item,
	input wire logic                             result_valid,
	input wire logic                             result_stall,
	input wire sdpg_pkg::result_t                result
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// A start request yields a running result next cycle
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.req_type |=>
		result_valid && result.motor_enable && result.run_status == sdpg_pkg::ST_RUNNING)
		else $error("start did not show a running cycle");

	a_done_off: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.cycle_done && result.motor_enable))
		else $error("cycle ended with motor still enabled");

	// A step drops the line and only happens inside a running cycle
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.step_taken |-> !result.step_level && result.motor_enable)
		else $error("step reported with line high or motor disabled");

endmodule

bind step_dir_pulse_generator sdpg_checker u_sdpg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
`default_nettype wire
